### sv/rti_pkg.sv
// ---------------------------------------------------------------------------
// rti_pkg
// Shared types, constants and micro-op table of the ray/triangle unit.
// ---------------------------------------------------------------------------
package rti_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int INDEX_WIDTH = 24;
  localparam int TRI_INDEX_W = 24;
  localparam int BARY_W      = 17;
  localparam int COORD_W     = 32;
  localparam int VEC_W       = COORD_W + 1;
  localparam int WIDE_W      = 68;
  localparam int MA_W        = 34;
  localparam int MB_W        = 36;
  localparam int PROD_W      = MA_W + MB_W;
  localparam int ACC_W       = 104;
  localparam int LIMB_W      = 32;
  localparam int HP_W        = 2 * COORD_W - FRAC_BITS + 1;
  localparam int DIV_NUM_W   = ACC_W + FRAC_BITS;
  localparam int DIV_DEN_W   = ACC_W;
  localparam int DIV_W       = 136;
  localparam int QUO_W       = 32;
  localparam int CNT_W       = 6;
  localparam int DIV_LONG_SHIFT = QUO_W - 1;
  localparam int DIV_LONG_STEPS = QUO_W;
  localparam int DIV_BARY_STEPS = FRAC_BITS + 1;
  localparam int CFG_IDX_W   = 3;
  localparam int STEP_W      = 6;
  localparam int MUL_STEPS   = 36;
  localparam int HIT_STEP0   = 36;
  localparam int HIT_STEPS   = 3;
  localparam int DRAIN_LAST  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_ORIGIN_Z,
    CFG_DIR_X, CFG_DIR_Y, CFG_DIR_Z, CFG_DET_MIN
  } cfg_idx_t;

  typedef enum logic [1:0] {AV_D, AV_E1, AV_E2, AV_S} avec_t;
  typedef enum logic [2:0] {BV_E1, BV_E2, BV_P, BV_Q, BV_T} bvec_t;
  typedef enum logic [1:0] {PT_FULL, PT_LO, PT_HI} part_t;
  typedef enum logic [3:0] {
    DS_NONE, DS_P0, DS_P1, DS_P2, DS_Q0, DS_Q1, DS_Q2,
    DS_DET, DS_UN, DS_VN, DS_TN, DS_H0, DS_H1, DS_H2
  } dst_t;

  typedef struct packed {
    avec_t      av;
    logic [1:0] ac;
    bvec_t      bv;
    logic [1:0] bc;
    part_t      part;
    logic       neg;
    logic       clr;
    dst_t       dst;
  } rti_op_t;

  typedef struct packed {
    logic            valid;
    logic [MA_W-1:0] a;
    logic [MB_W-1:0] b;
    logic            neg;
    logic            clr;
    logic            hi;
    dst_t            dst;
  } mac_op_t;

  typedef struct packed {
    logic valid;
    dst_t dst;
  } wb_t;

  typedef struct packed {
    logic start;
    logic long_mode;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  typedef struct packed {
    logic                      first_of_batch;
    logic signed [COORD_W-1:0] v0_x;
    logic signed [COORD_W-1:0] v0_y;
    logic signed [COORD_W-1:0] v0_z;
    logic signed [COORD_W-1:0] v1_x;
    logic signed [COORD_W-1:0] v1_y;
    logic signed [COORD_W-1:0] v1_z;
    logic signed [COORD_W-1:0] v2_x;
    logic signed [COORD_W-1:0] v2_y;
    logic signed [COORD_W-1:0] v2_z;
  } tri_beat_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] hit_distance;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic signed [COORD_W-1:0] hit_z;
    logic [BARY_W-1:0]         bary_u;
    logic [BARY_W-1:0]         bary_v;
    logic [TRI_INDEX_W-1:0]    tri_index;
  } hit_beat_t;

  function automatic logic [1:0] inc3(input logic [1:0] c);
    return (c == 2'd2) ? 2'd0 : c + 2'd1;
  endfunction

  function automatic dst_t dsel(input logic [1:0] c, input dst_t d0, input dst_t d1,
                                input dst_t d2);
    dst_t r;
    case (c)
      2'd0: r = d0;
      2'd1: r = d1;
      default: r = d2;
    endcase
    return r;
  endfunction

  // component c of a x b, two products per component
  function automatic rti_op_t cross_op(input avec_t av, input bvec_t bv,
                                       input logic [2:0] j, input dst_t d0,
                                       input dst_t d1, input dst_t d2);
    rti_op_t    op;
    logic [1:0] c;
    c       = j[2:1];
    op.av   = av;
    op.bv   = bv;
    op.part = PT_FULL;
    op.neg  = j[0];
    op.clr  = !j[0];
    op.ac   = j[0] ? inc3(inc3(c)) : inc3(c);
    op.bc   = j[0] ? inc3(c) : inc3(inc3(c));
    op.dst  = j[0] ? dsel(c, d0, d1, d2) : DS_NONE;
    return op;
  endfunction

  // dot product against a wide vector, two limbs per component
  function automatic rti_op_t dot_op(input avec_t av, input bvec_t bv,
                                     input logic [2:0] j, input dst_t d);
    rti_op_t op;
    op.av   = av;
    op.bv   = bv;
    op.ac   = j[2:1];
    op.bc   = j[2:1];
    op.part = j[0] ? PT_HI : PT_LO;
    op.neg  = 1'b0;
    op.clr  = (j == 3'd0);
    op.dst  = (j == 3'd5) ? d : DS_NONE;
    return op;
  endfunction

  function automatic rti_op_t rti_op(input logic [STEP_W-1:0] step);
    rti_op_t           op;
    logic [STEP_W-1:0] j;
    op = '0;
    j  = '0;
    if (step < STEP_W'(6)) begin
      op = cross_op(AV_D, BV_E2, step[2:0], DS_P0, DS_P1, DS_P2);
    end else if (step < STEP_W'(12)) begin
      j  = step - STEP_W'(6);
      op = dot_op(AV_E1, BV_P, j[2:0], DS_DET);
    end else if (step < STEP_W'(18)) begin
      j  = step - STEP_W'(12);
      op = dot_op(AV_S, BV_P, j[2:0], DS_UN);
    end else if (step < STEP_W'(24)) begin
      j  = step - STEP_W'(18);
      op = cross_op(AV_S, BV_E1, j[2:0], DS_Q0, DS_Q1, DS_Q2);
    end else if (step < STEP_W'(30)) begin
      j  = step - STEP_W'(24);
      op = dot_op(AV_D, BV_Q, j[2:0], DS_VN);
    end else if (step < STEP_W'(MUL_STEPS)) begin
      j  = step - STEP_W'(30);
      op = dot_op(AV_E2, BV_Q, j[2:0], DS_TN);
    end else begin
      j       = step - STEP_W'(HIT_STEP0);
      op.av   = AV_D;
      op.ac   = j[1:0];
      op.bv   = BV_T;
      op.bc   = 2'd0;
      op.part = PT_FULL;
      op.neg  = 1'b0;
      op.clr  = 1'b1;
      op.dst  = dsel(j[1:0], DS_H0, DS_H1, DS_H2);
    end
    return op;
  endfunction

endpackage

### sv/rti_mac.sv
// ---------------------------------------------------------------------------
// rti_mac
// Shared signed multiplier with a registered product and a wide accumulator.
// ---------------------------------------------------------------------------
module rti_mac (
  input  logic                       clk,
  input  logic                       rst,
  input  rti_pkg::mac_op_t           op,
  output logic [rti_pkg::ACC_W-1:0]  acc,
  output rti_pkg::wb_t               wb
);
  import rti_pkg::*;

  logic [PROD_W-1:0] prod;
  mac_op_t           ctl;
  logic [ACC_W-1:0]  ext;
  logic [ACC_W-1:0]  shifted;
  logic [ACC_W-1:0]  term;
  logic [ACC_W-1:0]  acc_next;

  always_comb begin
    ext      = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    shifted  = ctl.hi ? (ext << LIMB_W) : ext;
    term     = ctl.neg ? (~shifted + ACC_W'(1)) : shifted;
    acc_next = ctl.clr ? term : acc + term;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
      wb.valid  <= 1'b0;
    end else begin
      ctl.valid <= op.valid;
      wb.valid  <= ctl.valid;
    end
    prod    <= PROD_W'($signed(op.a) * $signed(op.b));
    ctl.a   <= op.a;
    ctl.b   <= op.b;
    ctl.neg <= op.neg;
    ctl.clr <= op.clr;
    ctl.hi  <= op.hi;
    ctl.dst <= op.dst;
    wb.dst  <= ctl.dst;
    if (ctl.valid) begin
      acc <= acc_next;
    end
  end

endmodule

### sv/rti_div.sv
// ---------------------------------------------------------------------------
// rti_div
// Restoring divider, one quotient bit per cycle, fixed pre-shift per mode.
// ---------------------------------------------------------------------------
module rti_div (
  input  logic                          clk,
  input  logic                          rst,
  input  rti_pkg::div_req_t             req,
  input  logic [rti_pkg::DIV_NUM_W-1:0] num,
  input  logic [rti_pkg::DIV_DEN_W-1:0] den,
  output rti_pkg::div_sts_t             sts,
  output logic [rti_pkg::QUO_W-1:0]     quo
);
  import rti_pkg::*;

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0]   diff;
  logic             ge;

  assign diff = {1'b0, rem} - {1'b0, dsr};
  assign ge   = !diff[DIV_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      sts.busy <= 1'b0;
      sts.done <= 1'b0;
    end else begin
      sts.done <= 1'b0;
      if (req.start) begin
        sts.busy <= 1'b1;
      end else if (sts.busy && cnt == CNT_W'(1)) begin
        sts.busy <= 1'b0;
        sts.done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= DIV_W'(num);
      dsr <= req.long_mode ? (DIV_W'(den) << DIV_LONG_SHIFT) : (DIV_W'(den) << FRAC_BITS);
      cnt <= req.long_mode ? CNT_W'(DIV_LONG_STEPS) : CNT_W'(DIV_BARY_STEPS);
      quo <= '0;
    end else if (sts.busy) begin
      if (ge) begin
        rem <= diff[DIV_W-1:0];
      end
      quo <= {quo[QUO_W-2:0], ge};
      dsr <= dsr >> 1;
      cnt <= cnt - CNT_W'(1);
    end
  end

endmodule

### sv/ray_triangle_intersect_unit.sv
// ---------------------------------------------------------------------------
// ray_triangle_intersect_unit
// Fixed-point Moller-Trumbore ray/triangle test with backface culling.
// ---------------------------------------------------------------------------
// One triangle is taken at a time; the next is taken once the previous one
// is rejected or its hit is loaded into the output register, which waits
// while an earlier hit beat is held by stall. The work is set by the one shared
// 34x36 multiplier, which forms the 39 products of the two cross products,
// four dot products and the hit point, and by the bit-per-cycle divider,
// which runs 32 steps for the distance and 17 each for u and v. A finished
// hit waits in the output register, so the next triangle may be taken while
// it is still stalled. The user must write the ray and det_min only while
// the unit is idle; the block itself does not enforce this.
module ray_triangle_intersect_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          tri_valid,
  output logic                          tri_stall,
  input  rti_pkg::tri_beat_t            tri_data,
  output logic                          hit_valid,
  input  logic                          hit_stall,
  output rti_pkg::hit_beat_t            hit_data
);
  import rti_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DRAIN, S_CHECK, S_DIV_T, S_DIV_U, S_DIV_V,
    S_HIT, S_HDRAIN, S_FINISH
  } state_t;

  state_t               state;
  logic [STEP_W-1:0]    step;
  logic [1:0]           drain;
  logic [INDEX_WIDTH-1:0] tri_count;
  logic [INDEX_WIDTH-1:0] idx_cur;

  logic [COORD_W-1:0]   org [3];
  logic [COORD_W-1:0]   dir [3];
  logic [31:0]          det_min;

  logic [VEC_W-1:0]     e1 [3];
  logic [VEC_W-1:0]     e2 [3];
  logic [VEC_W-1:0]     sv [3];
  logic [WIDE_W-1:0]    pw [3];
  logic [WIDE_W-1:0]    qw [3];
  logic [63:0]          hw [3];
  logic signed [ACC_W-1:0] det, un, vn, tn;
  logic [COORD_W-1:0]   t_q;
  logic [BARY_W-1:0]    bu, bv;

  logic                 acc_in;
  rti_op_t              uop;
  mac_op_t              mop;
  logic [ACC_W-1:0]     acc;
  wb_t                  wb;
  div_req_t             dreq;
  div_sts_t             dsts;
  logic [DIV_NUM_W-1:0] dnum;
  logic [QUO_W-1:0]     quo;
  logic                 pass;
  logic [ACC_W-1:0]     tmag;
  logic [COORD_W-1:0]   t_new;
  logic [VEC_W-1:0]     va;
  logic [WIDE_W-1:0]    wsel;
  logic [VEC_W-1:0]     nsel;
  logic signed [ACC_W:0] uv_sum;
  logic [COORD_W-1:0]   v0 [3];
  logic [COORD_W-1:0]   v1 [3];
  logic [COORD_W-1:0]   v2 [3];

  function automatic logic [VEC_W-1:0] sx33(input logic [COORD_W-1:0] x);
    return {x[COORD_W-1], x};
  endfunction

  function automatic logic [COORD_W-1:0] sat_hit(input logic [COORD_W-1:0] o,
                                                 input logic [63:0] h);
    logic [HP_W-1:0] s;
    s = {{(HP_W-COORD_W){o[COORD_W-1]}}, o} + {h[63], h[63:FRAC_BITS]};
    if (s[HP_W-1:COORD_W-1] == '0 || s[HP_W-1:COORD_W-1] == '1) begin
      return s[COORD_W-1:0];
    end
    return s[HP_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

  assign acc_in    = tri_valid && !tri_stall;
  assign tri_stall = (state != S_IDLE);

  assign v0[0] = tri_data.v0_x;
  assign v0[1] = tri_data.v0_y;
  assign v0[2] = tri_data.v0_z;
  assign v1[0] = tri_data.v1_x;
  assign v1[1] = tri_data.v1_y;
  assign v1[2] = tri_data.v1_z;
  assign v2[0] = tri_data.v2_x;
  assign v2[1] = tri_data.v2_y;
  assign v2[2] = tri_data.v2_z;

  // operand select for the shared multiplier
  always_comb begin
    uop = rti_op(step);
    case (uop.ac)
      2'd0: va = (uop.av == AV_D) ? sx33(dir[0]) : (uop.av == AV_E1) ? e1[0] :
                 (uop.av == AV_E2) ? e2[0] : sv[0];
      2'd1: va = (uop.av == AV_D) ? sx33(dir[1]) : (uop.av == AV_E1) ? e1[1] :
                 (uop.av == AV_E2) ? e2[1] : sv[1];
      default: va = (uop.av == AV_D) ? sx33(dir[2]) : (uop.av == AV_E1) ? e1[2] :
                    (uop.av == AV_E2) ? e2[2] : sv[2];
    endcase
    case (uop.bc)
      2'd0: begin
        wsel = (uop.bv == BV_P) ? pw[0] : qw[0];
        nsel = (uop.bv == BV_E1) ? e1[0] : e2[0];
      end
      2'd1: begin
        wsel = (uop.bv == BV_P) ? pw[1] : qw[1];
        nsel = (uop.bv == BV_E1) ? e1[1] : e2[1];
      end
      default: begin
        wsel = (uop.bv == BV_P) ? pw[2] : qw[2];
        nsel = (uop.bv == BV_E1) ? e1[2] : e2[2];
      end
    endcase
    mop.valid = (state == S_MUL) || (state == S_HIT);
    mop.a     = {va[VEC_W-1], va};
    case (uop.bv)
      BV_E1, BV_E2: mop.b = {{(MB_W-VEC_W){nsel[VEC_W-1]}}, nsel};
      BV_P, BV_Q: begin
        case (uop.part)
          PT_LO:   mop.b = {{(MB_W-LIMB_W){1'b0}}, wsel[LIMB_W-1:0]};
          PT_HI:   mop.b = wsel[WIDE_W-1:LIMB_W];
          default: mop.b = wsel[MB_W-1:0];
        endcase
      end
      BV_T:    mop.b = {{(MB_W-COORD_W){t_q[COORD_W-1]}}, t_q};
      default: mop.b = '0;
    endcase
    mop.neg = uop.neg;
    mop.clr = uop.clr;
    mop.hi  = (uop.part == PT_HI);
    mop.dst = uop.dst;
  end

  rti_mac u_mac (
    .clk (clk),
    .rst (rst),
    .op  (mop),
    .acc (acc),
    .wb  (wb)
  );

  // exact rejection tests on the numerators
  always_comb begin
    uv_sum = {un[ACC_W-1], un} + {vn[ACC_W-1], vn};
    pass   = !det[ACC_W-1] && (det != '0) &&
             ($unsigned(det) >= {{(ACC_W-32-FRAC_BITS){1'b0}}, det_min, {FRAC_BITS{1'b0}}}) &&
             !un[ACC_W-1] && (un <= det) && !vn[ACC_W-1] &&
             (uv_sum <= {det[ACC_W-1], det});
    tmag   = tn[ACC_W-1] ? (~tn + ACC_W'(1)) : tn;
  end

  always_comb begin
    dreq.start     = 1'b0;
    dreq.long_mode = 1'b0;
    dnum           = {tmag, {FRAC_BITS{1'b0}}};
    case (state)
      S_CHECK: begin
        dreq.start     = pass;
        dreq.long_mode = 1'b1;
      end
      S_DIV_T: begin
        dreq.start = dsts.done;
        dnum       = {un, {FRAC_BITS{1'b0}}};
      end
      S_DIV_U: begin
        dreq.start = dsts.done;
        dnum       = {vn, {FRAC_BITS{1'b0}}};
      end
      default: begin
        dreq.start = 1'b0;
      end
    endcase
  end

  rti_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .num (dnum),
    .den (det),
    .sts (dsts),
    .quo (quo)
  );

  // signed, saturated distance from the magnitude quotient
  always_comb begin
    if (tn[ACC_W-1]) begin
      t_new = quo[QUO_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : (~quo + COORD_W'(1));
    end else begin
      t_new = quo[QUO_W-1] ? {1'b0, {(COORD_W-1){1'b1}}} : quo;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      org[0]  <= '0;
      org[1]  <= '0;
      org[2]  <= '0;
      dir[0]  <= '0;
      dir[1]  <= '0;
      dir[2]  <= 32'hFFFF_0000;
      det_min <= 32'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X: org[0]  <= cfg_data;
        CFG_ORIGIN_Y: org[1]  <= cfg_data;
        CFG_ORIGIN_Z: org[2]  <= cfg_data;
        CFG_DIR_X:    dir[0]  <= cfg_data;
        CFG_DIR_Y:    dir[1]  <= cfg_data;
        CFG_DIR_Z:    dir[2]  <= cfg_data;
        CFG_DET_MIN:  det_min <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      drain     <= '0;
      tri_count <= '0;
      hit_valid <= 1'b0;
    end else begin
      if (hit_valid && !hit_stall && state != S_FINISH) begin
        hit_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc_in) begin
            tri_count <= (tri_data.first_of_batch ? '0 : tri_count) + INDEX_WIDTH'(1);
            step      <= '0;
            state     <= S_MUL;
          end
        end
        S_MUL: begin
          step <= step + STEP_W'(1);
          if (step == STEP_W'(MUL_STEPS - 1)) begin
            drain <= '0;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          drain <= drain + 2'd1;
          if (drain == 2'(DRAIN_LAST)) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= pass ? S_DIV_T : S_IDLE;
        end
        S_DIV_T: begin
          if (dsts.done) begin
            state <= S_DIV_U;
          end
        end
        S_DIV_U: begin
          if (dsts.done) begin
            state <= S_DIV_V;
          end
        end
        S_DIV_V: begin
          if (dsts.done) begin
            step  <= STEP_W'(HIT_STEP0);
            state <= S_HIT;
          end
        end
        S_HIT: begin
          step <= step + STEP_W'(1);
          if (step == STEP_W'(HIT_STEP0 + HIT_STEPS - 1)) begin
            drain <= '0;
            state <= S_HDRAIN;
          end
        end
        S_HDRAIN: begin
          drain <= drain + 2'd1;
          if (drain == 2'(DRAIN_LAST)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!hit_valid || !hit_stall) begin
            hit_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (acc_in) begin
      idx_cur <= tri_data.first_of_batch ? '0 : tri_count;
      for (int i = 0; i < 3; i++) begin
        e1[i] <= sx33(v1[i]) - sx33(v0[i]);
        e2[i] <= sx33(v2[i]) - sx33(v0[i]);
        sv[i] <= sx33(org[i]) - sx33(v0[i]);
      end
    end
    if (wb.valid) begin
      case (wb.dst)
        DS_P0:  pw[0] <= acc[WIDE_W-1:0];
        DS_P1:  pw[1] <= acc[WIDE_W-1:0];
        DS_P2:  pw[2] <= acc[WIDE_W-1:0];
        DS_Q0:  qw[0] <= acc[WIDE_W-1:0];
        DS_Q1:  qw[1] <= acc[WIDE_W-1:0];
        DS_Q2:  qw[2] <= acc[WIDE_W-1:0];
        DS_DET: det   <= acc;
        DS_UN:  un    <= acc;
        DS_VN:  vn    <= acc;
        DS_TN:  tn    <= acc;
        DS_H0:  hw[0] <= acc[63:0];
        DS_H1:  hw[1] <= acc[63:0];
        DS_H2:  hw[2] <= acc[63:0];
        default: ;
      endcase
    end
    if (state == S_DIV_T && dsts.done) begin
      t_q <= t_new;
    end
    if (state == S_DIV_U && dsts.done) begin
      bu <= quo[BARY_W-1:0];
    end
    if (state == S_DIV_V && dsts.done) begin
      bv <= quo[BARY_W-1:0];
    end
    if (state == S_FINISH && (!hit_valid || !hit_stall)) begin
      hit_data.hit_distance <= t_q;
      hit_data.hit_x        <= sat_hit(org[0], hw[0]);
      hit_data.hit_y        <= sat_hit(org[1], hw[1]);
      hit_data.hit_z        <= sat_hit(org[2], hw[2]);
      hit_data.bary_u       <= bu;
      hit_data.bary_v       <= bv;
      hit_data.tri_index    <= TRI_INDEX_W'(idx_cur);
    end
  end

`ifndef SYNTHESIS
  a_bary_u_range: assert property (@(posedge clk) disable iff (rst)
    hit_valid |-> hit_data.bary_u <= BARY_W'(1 << FRAC_BITS))
    else $error("bary_u above one");

  a_bary_sum_range: assert property (@(posedge clk) disable iff (rst)
    hit_valid |-> ({1'b0, hit_data.bary_u} + {1'b0, hit_data.bary_v}) <=
                  (BARY_W+1)'(1 << FRAC_BITS))
    else $error("bary_u plus bary_v above one");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    tri_valid && !tri_stall |=> tri_stall)
    else $error("new triangle taken while busy");

  a_hit_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(hit_valid) |-> $past(state == S_FINISH))
    else $error("hit beat raised outside finish");
`endif

endmodule

### sim/hit_checker.sv
// ---------------------------------------------------------------------------
// hit_checker
// Watches the config port and both channels of ray_triangle_intersect_unit.
// Predicts each triangle's hit from its own ray copy and compares results.
// ---------------------------------------------------------------------------
module hit_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               tri_valid,
  input  logic               tri_stall,
  input  rti_pkg::tri_beat_t tri_data,
  input  logic               hit_valid,
  input  logic               hit_stall,
  input  rti_pkg::hit_beat_t hit_data,
  output int                 fail_count,
  output int                 waiting_hits,
  output int                 triangles_seen,
  output int                 hits_seen
);
  import rti_pkg::*;

  typedef logic signed [127:0] wide_t;

  logic signed [31:0] ray_org [3];
  logic signed [31:0] ray_dir [3];
  logic [31:0]        det_floor;
  logic [23:0]        next_index;
  hit_beat_t          expected_hits [$];

  function automatic logic signed [31:0] frac_div(input wide_t n, input wide_t d);
    wide_t quo;
    quo = (n <<< FRAC_BITS) / d;
    if (quo > wide_t'(32'sh7fffffff)) return 32'sh7fffffff;
    if (quo < -wide_t'(64'sh80000000)) return 32'sh80000000;
    return quo[31:0];
  endfunction

  function automatic bit predict_hit(input tri_beat_t b, input logic [23:0] idx,
                                     output hit_beat_t r);
    wide_t v0 [3], e1 [3], e2 [3], s [3], d [3], p [3], q [3];
    wide_t det, un, vn, tn, thr;
    logic signed [63:0] t, h, prod;
    v0[0] = b.v0_x; v0[1] = b.v0_y; v0[2] = b.v0_z;
    e1[0] = wide_t'(b.v1_x) - v0[0];
    e1[1] = wide_t'(b.v1_y) - v0[1];
    e1[2] = wide_t'(b.v1_z) - v0[2];
    e2[0] = wide_t'(b.v2_x) - v0[0];
    e2[1] = wide_t'(b.v2_y) - v0[1];
    e2[2] = wide_t'(b.v2_z) - v0[2];
    for (int i = 0; i < 3; i++) begin
      d[i] = ray_dir[i];
      s[i] = wide_t'(ray_org[i]) - v0[i];
    end
    p[0] = d[1] * e2[2] - d[2] * e2[1];
    p[1] = d[2] * e2[0] - d[0] * e2[2];
    p[2] = d[0] * e2[1] - d[1] * e2[0];
    det = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
    thr = wide_t'({96'b0, det_floor}) <<< FRAC_BITS;
    r = '0;
    if (det <= 0 || det < thr) return 0;
    un = s[0] * p[0] + s[1] * p[1] + s[2] * p[2];
    if (un < 0 || un > det) return 0;
    q[0] = s[1] * e1[2] - s[2] * e1[1];
    q[1] = s[2] * e1[0] - s[0] * e1[2];
    q[2] = s[0] * e1[1] - s[1] * e1[0];
    vn = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
    if (vn < 0 || un + vn > det) return 0;
    tn = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    t = frac_div(tn, det);
    r.hit_distance = t[31:0];
    for (int i = 0; i < 3; i++) begin
      prod = 64'(ray_dir[i]) * t;
      h = 64'(ray_org[i]) + (prod >>> FRAC_BITS);
      if (h > 64'sh7fffffff) h = 64'sh7fffffff;
      if (h < -64'sh80000000) h = -64'sh80000000;
      case (i)
        0: r.hit_x = h[31:0];
        1: r.hit_y = h[31:0];
        default: r.hit_z = h[31:0];
      endcase
    end
    t = frac_div(un, det);
    r.bary_u = t[BARY_W-1:0];
    t = frac_div(vn, det);
    r.bary_v = t[BARY_W-1:0];
    r.tri_index = idx;
    return 1;
  endfunction

  always @(posedge clk) begin
    hit_beat_t  exp_hit;
    logic [23:0] idx;
    if (rst) begin
      foreach (ray_org[i]) ray_org[i] <= '0;
      ray_dir[0] <= '0;
      ray_dir[1] <= '0;
      ray_dir[2] <= 32'shffff0000;
      det_floor  <= 32'd1;
      next_index <= '0;
      expected_hits.delete();
      fail_count     <= 0;
      waiting_hits   <= 0;
      triangles_seen <= 0;
      hits_seen      <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ORIGIN_X: ray_org[0] <= cfg_data;
          CFG_ORIGIN_Y: ray_org[1] <= cfg_data;
          CFG_ORIGIN_Z: ray_org[2] <= cfg_data;
          CFG_DIR_X:    ray_dir[0] <= cfg_data;
          CFG_DIR_Y:    ray_dir[1] <= cfg_data;
          CFG_DIR_Z:    ray_dir[2] <= cfg_data;
          CFG_DET_MIN:  det_floor  <= cfg_data;
          default: ;
        endcase
      end
      if (hit_valid && !hit_stall) begin
        hits_seen <= hits_seen + 1;
        if (expected_hits.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected hit beat %p", hit_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_hit = expected_hits.pop_front();
          if (exp_hit != hit_data) begin
            if (fail_count < 10)
              $display("hit mismatch\n  expected %p\n  actual   %p", exp_hit, hit_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (tri_valid && !tri_stall) begin
        triangles_seen <= triangles_seen + 1;
        idx = tri_data.first_of_batch ? 24'd0 : next_index;
        next_index <= idx + 24'd1;
        if (predict_hit(tri_data, idx, exp_hit))
          expected_hits.insert(expected_hits.size(), exp_hit);
      end
      waiting_hits <= expected_hits.size();
    end
  end
endmodule

### sim/ray_triangle_intersect_unit_test.sv
// ---------------------------------------------------------------------------
// ray_triangle_intersect_unit_test
// Streams directed and random triangles through several ray settings, with
// random gaps and output stalls; hit_checker predicts and compares hits.
// ---------------------------------------------------------------------------
module ray_triangle_intersect_unit_test;
  import rti_pkg::*;

  localparam int ONE = 65536;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic      clk;
  logic      rst;
  logic      cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic      tri_valid;
  logic      tri_stall;
  tri_beat_t tri_data;
  logic      hit_valid;
  logic      hit_stall;
  hit_beat_t hit_data;
  int        fail_count, waiting_hits, triangles_seen, hits_seen;
  bit        calm;
  longint    ray_o [3];
  longint    ray_d [3];

  ray_triangle_intersect_unit dut (.*);

  hit_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("ray_triangle_intersect_unit test failed");
    $finish;
  end

  // output stall bursts
  initial begin
    hit_stall = 0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(3) == 0) begin
        hit_stall = 1;
        repeat ($urandom_range(17, 1)) @(negedge clk);
        hit_stall = 0;
        repeat ($urandom_range(30, 1)) @(negedge clk);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = value;
    if (idx < 3) ray_o[idx] = longint'($signed(value));
    else if (idx < 6) ray_d[idx - 3] = longint'($signed(value));
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_ray(input int ox, input int oy, input int oz, input int dx,
                         input int dy, input int dz, input logic [31:0] dmin);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_DIR_X, dx);
    write_reg(CFG_DIR_Y, dy);
    write_reg(CFG_DIR_Z, dz);
    write_reg(CFG_DET_MIN, dmin);
  endtask

  task automatic send_triangle(input tri_beat_t b);
    if (!calm && $urandom_range(3) == 0) begin
      tri_valid = 0;
      repeat ($urandom_range(17, 1)) @(negedge clk);
    end
    tri_valid = 1;
    tri_data = b;
    #1;
    while (tri_stall) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
  endtask

  // wait for every hit, then let a rejected triangle finish too
  task automatic drain();
    tri_valid = 0;
    @(negedge clk);
    while (waiting_hits != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  function automatic tri_beat_t make_tri(input bit fb, input int x0, input int y0,
                                         input int z0, input int x1, input int y1,
                                         input int z1, input int x2, input int y2,
                                         input int z2);
    tri_beat_t r;
    r.first_of_batch = fb;
    r.v0_x = x0; r.v0_y = y0; r.v0_z = z0;
    r.v1_x = x1; r.v1_y = y1; r.v1_z = z1;
    r.v2_x = x2; r.v2_y = y2; r.v2_z = z2;
    return r;
  endfunction

  // triangle whose centroid lies on the ray, random winding
  function automatic tri_beat_t aimed_triangle();
    longint t, c [3], a [3], b [3], w0 [3], w1 [3], w2 [3];
    tri_beat_t r;
    t = longint'($urandom_range(20 * ONE));
    if ($urandom_range(7) == 0) t = t - 30 * ONE;
    for (int i = 0; i < 3; i++) begin
      c[i] = ray_o[i] + ((ray_d[i] * t) >>> FRAC_BITS);
      a[i] = longint'($urandom_range(16 * ONE)) - 8 * ONE;
      b[i] = longint'($urandom_range(16 * ONE)) - 8 * ONE;
      w0[i] = c[i] + a[i];
      w1[i] = c[i] + b[i];
      w2[i] = c[i] - a[i] - b[i];
    end
    if ($urandom_range(1)) begin
      w1 = w2;
      for (int i = 0; i < 3; i++) w2[i] = c[i] + b[i];
    end
    r = make_tri($urandom_range(15) == 0, int'(w0[0]), int'(w0[1]), int'(w0[2]),
                 int'(w1[0]), int'(w1[1]), int'(w1[2]),
                 int'(w2[0]), int'(w2[1]), int'(w2[2]));
    return r;
  endfunction

  function automatic tri_beat_t noise_triangle();
    tri_beat_t r;
    r = make_tri($urandom_range(1), $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom);
    return r;
  endfunction

  task automatic random_run(input int count);
    for (int n = 0; n < count; n++)
      send_triangle($urandom_range(9) < 7 ? aimed_triangle() : noise_triangle());
  endtask

  initial begin
    int mx, mn;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    calm = 0;
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    tri_valid = 0;
    tri_data = '0;
    ray_o = '{0, 0, 0};
    ray_d = '{0, 0, -ONE};
    repeat (11) @(negedge clk);
    rst = 0;
    @(negedge clk);

    // directed beats on the reset ray
    send_triangle(make_tri(1, -ONE, -ONE, -ONE, ONE, -ONE, -ONE, -ONE, ONE, -ONE));
    send_triangle(make_tri(0, -ONE, -ONE, -ONE, -ONE, ONE, -ONE, ONE, -ONE, -ONE));
    send_triangle(make_tri(0, 0, 0, -2 * ONE, ONE, 0, -2 * ONE, 0, ONE, -2 * ONE));
    send_triangle(make_tri(0, -ONE, -ONE, -3 * ONE, 3 * ONE, -ONE, -3 * ONE,
                           -ONE, 3 * ONE, -3 * ONE));
    send_triangle(make_tri(0, ONE, ONE, -ONE, 2 * ONE, ONE, -ONE, ONE, 2 * ONE, -ONE));
    send_triangle(make_tri(0, 5, 5, 5, 5, 5, 5, 5, 5, 5));
    send_triangle(make_tri(0, -ONE, -ONE, 2 * ONE, ONE, -ONE, 2 * ONE,
                           -ONE, ONE, 2 * ONE));
    send_triangle(make_tri(1, mn, mn, mn, mn, mn, mn, mn, mn, mn));
    send_triangle(make_tri(0, mx, mx, mx, mx, mx, mx, mx, mx, mx));
    send_triangle(make_tri(0, mn, mn, mn, mx, mn, mx, mn, mx, mx));
    send_triangle(make_tri(0, mx, mx, mx, mn, mx, mn, mx, mn, mn));
    send_triangle(make_tri(0, mn, mn, 0, mx, mn, 0, mn, mx, 0));
    send_triangle(make_tri(0, -128, -128, -ONE, 128, -128, -ONE, -128, 128, -ONE));
    send_triangle(make_tri(0, -128, -128, -ONE, 127, -128, -ONE, -128, 128, -ONE));
    send_triangle(make_tri(1, -ONE, -ONE, -32767 * ONE, ONE, -ONE, -32767 * ONE,
                           -ONE, ONE, -32767 * ONE));
    send_triangle(make_tri(0, -ONE, -ONE, -ONE, ONE, -ONE, -ONE, -ONE, ONE, -ONE));
    random_run(140);
    drain();

    write_reg(CFG_UNUSED, 32'hffffffff);
    set_ray(ONE + ONE / 2, -2 * ONE, 3 * ONE, ONE / 4, ONE / 2, -ONE, 0);
    random_run(160);
    drain();

    set_ray(int'($urandom_range(32 * ONE)) - 16 * ONE,
            int'($urandom_range(32 * ONE)) - 16 * ONE,
            int'($urandom_range(32 * ONE)) - 16 * ONE,
            int'($urandom_range(4 * ONE)) - 2 * ONE,
            int'($urandom_range(4 * ONE)) - 2 * ONE,
            int'($urandom_range(4 * ONE)) - 2 * ONE, $urandom_range(255));
    random_run(160);
    drain();

    set_ray(mx, mn, 0, mx, mn, ONE, 32'hffffffff);
    random_run(100);
    drain();

    set_ray(0, 0, 0, 1, 0, -1, 0);
    random_run(100);
    drain();

    set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    random_run(100);
    drain();

    // last stretch without idling
    set_ray(0, 0, 0, 0, 0, -ONE, 1);
    calm = 1;
    hit_stall = 0;
    random_run(200);
    drain();

    $display("%0d triangles over seven ray settings, %0d hits checked",
             triangles_seen, hits_seen);
    $display("directed edges, extremes and threshold cases plus aimed and random triangles");
    if (fail_count == 0 && waiting_hits == 0) begin
      $display("ray_triangle_intersect_unit test passed");
    end else begin
      $display("ray_triangle_intersect_unit test failed");
    end
    $finish;
  end
endmodule
